// ===== hw/rtl/ifhf_pkg.sv =====
// Package for the IMU frame heading filter: constants, CORDIC table, shared types.
// Used by all modules under hw/rtl; no dependencies.
`timescale 1ns / 1ps
package ifhf_pkg;
	localparam int Window = 8;
	localparam int CordicSteps = 16;
	localparam int WinIdxW = $clog2(Window);
	localparam int StepW = $clog2(CordicSteps + 1);
	localparam logic [7:0] SyncByte = 8'h55;
	localparam logic [7:0] AngleType = 8'h53;
	localparam logic [3:0] FrameLen = 4'd11;
	localparam logic [31:0] XInit = 32'sd5093946;
	// Accumulator width: sums of Window Q1.15 values scaled by 65536, plus CORDIC growth.
	localparam int AccW = 16 + $clog2(Window) + 16 + 3;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic [31:0] atan_of(input logic [4:0] i);
		case (i)
			5'd0: return 32'd536870912;
			5'd1: return 32'd316933406;
			5'd2: return 32'd167458907;
			5'd3: return 32'd85004756;
			5'd4: return 32'd42667331;
			5'd5: return 32'd21354465;
			5'd6: return 32'd10679838;
			5'd7: return 32'd5340245;
			5'd8: return 32'd2670163;
			5'd9: return 32'd1335087;
			5'd10: return 32'd667544;
			5'd11: return 32'd333772;
			5'd12: return 32'd166886;
			5'd13: return 32'd83443;
			5'd14: return 32'd41721;
			5'd15: return 32'd20860;
			5'd16: return 32'd10430;
			5'd17: return 32'd5215;
			5'd18: return 32'd2607;
			5'd19: return 32'd1303;
			5'd20: return 32'd651;
			5'd21: return 32'd325;
			5'd22: return 32'd162;
			5'd23: return 32'd81;
			default: return 32'd0;
		endcase
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT_LOAD,
		ST_ROT_RUN,
		ST_ROT_DONE,
		ST_VEC_LOAD,
		ST_VEC_RUN,
		ST_VEC_DONE,
		ST_SCAN,
		ST_TRIM,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rot_load;
		logic vec_load;
		logic step;
		logic rot_done;
		logic mean_done;
		logic scan;
		logic trim;
		logic final_done;
		logic clr_sums;
		logic idx_inc;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic steps_done;
		logic last_idx;
		logic second_pass;
		logic scan_done;
	} stat_t;
endpackage

// ===== hw/rtl/ifhf_ctrl.sv =====
// Controller for the heading filter: sequences CORDIC rotations, mean, trim, final atan2.
// Depends on ifhf_pkg.
`timescale 1ns / 1ps
module ifhf_ctrl import ifhf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output logic  done,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_ROT_LOAD;
			ST_ROT_LOAD: state_d = ST_ROT_RUN;
			ST_ROT_RUN: if (stat.steps_done) state_d = ST_ROT_DONE;
			ST_ROT_DONE: state_d = stat.last_idx ? ST_VEC_LOAD : ST_ROT_LOAD;
			ST_VEC_LOAD: state_d = ST_VEC_RUN;
			ST_VEC_RUN: if (stat.steps_done) state_d = ST_VEC_DONE;
			ST_VEC_DONE: state_d = stat.second_pass ? ST_OUT : ST_SCAN;
			ST_SCAN: if (stat.scan_done) state_d = ST_TRIM;
			ST_TRIM: state_d = ST_VEC_LOAD;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: cmd.clr_sums = start;
			ST_ROT_LOAD: cmd.rot_load = 1'b1;
			ST_ROT_RUN: cmd.step = !stat.steps_done;
			ST_ROT_DONE: begin
				cmd.rot_done = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ST_VEC_LOAD: cmd.vec_load = 1'b1;
			ST_VEC_RUN: cmd.step = !stat.steps_done;
			ST_VEC_DONE: begin
				cmd.mean_done = !stat.second_pass;
				cmd.final_done = stat.second_pass;
			end
			ST_SCAN: cmd.scan = !stat.scan_done;
			ST_TRIM: cmd.trim = 1'b1;
			ST_OUT: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== hw/rtl/ifhf_dp.sv =====
// Datapath for the heading filter: window store, shared CORDIC, sums, trim search.
// Depends on ifhf_pkg.
`timescale 1ns / 1ps
module ifhf_dp import ifhf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [15:0]         wr_yaw,
	input  logic [WinIdxW-1:0]  wr_idx,
	input  cmd_t                cmd,
	output stat_t               stat,
	output logic [15:0]         result
);
	logic [15:0] win_q [Window];
	logic signed [15:0] cs_q [Window];
	logic signed [15:0] sn_q [Window];
	logic signed [AccW-1:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [StepW-1:0] step_q;
	logic [WinIdxW-1:0] idx_q;
	logic vec_q, flip_q, pass2_q, zero_q;
	logic [15:0] base_q, mean_q;
	logic signed [AccW-1:0] sum_c_q, sum_s_q;
	logic signed [16:0] dmin_q, dmax_q;
	logic [WinIdxW-1:0] imin_q, imax_q;
	logic [1:0] tphase_q;

	assign stat.steps_done = (step_q == StepW'(CordicSteps));
	assign stat.last_idx = (idx_q == WinIdxW'(Window - 1));
	assign stat.second_pass = pass2_q;
	assign stat.scan_done = (tphase_q == 2'd3);

	// One CORDIC micro-rotation.
	logic dir;
	logic signed [AccW-1:0] xs, ys;
	logic [31:0] at;
	always_comb begin
		dir = vec_q ? (y_q >= 0) : (z_q >= 0);
		xs = x_q >>> step_q;
		ys = y_q >>> step_q;
		at = atan_of(5'(step_q));
	end

	// Rotation result rounding to Q1.15 with clamp.
	function automatic logic signed [15:0] rnd(input logic signed [AccW-1:0] v, input logic f);
		logic signed [AccW-1:0] r;
		logic signed [15:0] c;
		r = (v + AccW'(128)) >>> 8;
		if (r > AccW'(32767)) c = 16'sd32767;
		else if (r < -AccW'(32767)) c = -16'sd32767;
		else c = r[15:0];
		return f ? -c : c;
	endfunction

	logic signed [AccW-1:0] rc, rs, vx, vy;
	logic [15:0] yaw_a, rd_yaw;
	logic [31:0] zr;
	always_comb begin
		rc = AccW'(rnd(x_q, flip_q));
		rs = AccW'(rnd(y_q, flip_q));
		rd_yaw = win_q[idx_q];
		yaw_a = ((rd_yaw + 16'h4000) & 16'h8000) != 0 ? rd_yaw ^ 16'h8000 : rd_yaw;
		vx = sum_c_q;
		vy = sum_s_q;
		zr = 32'((z_q + 32'sd32768) >>> 16);
	end

	// Deviation of the current index from the mean.
	logic [15:0] dv;
	logic signed [16:0] d;
	always_comb begin
		dv = win_q[idx_q] - mean_q;
		d = 17'(signed'(dv));
	end

	always_ff @(posedge clk) begin
		if (wr_en) win_q[wr_idx] <= wr_yaw;
		if (cmd.rot_done) begin
			cs_q[idx_q] <= rc[15:0];
			sn_q[idx_q] <= rs[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			idx_q <= '0;
			vec_q <= 1'b0;
			flip_q <= 1'b0;
			pass2_q <= 1'b0;
			zero_q <= 1'b0;
			tphase_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			base_q <= '0;
			mean_q <= '0;
			result <= '0;
			sum_c_q <= '0;
			sum_s_q <= '0;
			dmin_q <= '0;
			dmax_q <= '0;
			imin_q <= '0;
			imax_q <= '0;
		end else begin
			if (cmd.clr_sums) begin
				sum_c_q <= '0;
				sum_s_q <= '0;
				idx_q <= '0;
				pass2_q <= 1'b0;
			end
			if (cmd.rot_load) begin
				vec_q <= 1'b0;
				flip_q <= (yaw_a != rd_yaw);
				x_q <= AccW'(signed'(XInit));
				y_q <= '0;
				z_q <= {yaw_a, 16'h0000};
				step_q <= '0;
			end
			if (cmd.vec_load) begin
				vec_q <= 1'b1;
				zero_q <= (vx == 0) && (vy == 0);
				base_q <= (vx < 0) ? 16'h8000 : 16'h0000;
				x_q <= ((vx < 0) ? -vx : vx) <<< 16;
				y_q <= ((vx < 0) ? -vy : vy) <<< 16;
				z_q <= '0;
				step_q <= '0;
			end
			if (cmd.step) begin
				step_q <= step_q + 1'b1;
				if (dir) begin
					x_q <= vec_q ? x_q + ys : x_q - ys;
					y_q <= vec_q ? y_q - xs : y_q + xs;
					z_q <= vec_q ? z_q + signed'(at) : z_q - signed'(at);
				end else begin
					x_q <= vec_q ? x_q - ys : x_q + ys;
					y_q <= vec_q ? y_q + xs : y_q - xs;
					z_q <= vec_q ? z_q - signed'(at) : z_q + signed'(at);
				end
			end
			if (cmd.rot_done) begin
				sum_c_q <= sum_c_q + rc;
				sum_s_q <= sum_s_q + rs;
				idx_q <= cmd.idx_inc ? idx_q + 1'b1 : idx_q;
			end
			// Full-window mean; start the trim search.
			if (cmd.mean_done) begin
				mean_q <= zero_q ? 16'h0000 : base_q + zr[15:0];
				idx_q <= '0;
				tphase_q <= '0;
			end
			// Trim search: a min pass over the window, then a max pass that skips the min.
			// Phase 2 means no max candidate has been seen yet, phase 1 that one has.
			if (cmd.scan) begin
				if (tphase_q == 2'd0) begin
					if (idx_q == 0 || d < dmin_q) begin
						dmin_q <= d;
						imin_q <= idx_q;
					end
				end else if (idx_q != imin_q && (tphase_q == 2'd2 || d > dmax_q)) begin
					dmax_q <= d;
					imax_q <= idx_q;
				end
				if (idx_q == WinIdxW'(Window - 1)) begin
					idx_q <= '0;
					tphase_q <= (tphase_q == 2'd0) ? 2'd2 : 2'd3;
				end else begin
					idx_q <= idx_q + 1'b1;
					if (tphase_q == 2'd2 && idx_q != imin_q) tphase_q <= 2'd1;
				end
			end
			// Drop the two trimmed samples from the sums.
			if (cmd.trim) begin
				pass2_q <= 1'b1;
				sum_c_q <= sum_c_q - AccW'(cs_q[imin_q]) - AccW'(cs_q[imax_q]);
				sum_s_q <= sum_s_q - AccW'(sn_q[imin_q]) - AccW'(sn_q[imax_q]);
			end
			if (cmd.final_done) begin
				result <= zero_q ? 16'h0000 : base_q + zr[15:0];
			end
		end
	end
endmodule

// ===== hw/rtl/imu_frame_heading_filter_core.sv =====
// Top level of the IMU frame heading filter: framing, config port, output register.
// Depends on ifhf_pkg, ifhf_ctrl and ifhf_dp.
`timescale 1ns / 1ps
// Bytes are taken one per cycle while no heading is being computed or waiting
// in the output register. Each accepted angle frame with a full window starts
// one shared CORDIC unit that runs eight rotations, a vectoring pass for the
// mean, a trim scan (a min pass, then a max pass), the trim and a second
// vectoring pass. The heading then waits in an output register.
module imu_frame_heading_filter_core import ifhf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_byte_valid,
	output logic        rx_byte_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] heading,
	output logic [8:0]  heading_deg,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [15:0] offset_q;
	logic [3:0] byte_count_q;
	logic [7:0] type_q, yaw_lo_q;
	logic [WinIdxW-1:0] pos_q;
	logic full_q, busy, done, start, acc, wr_en;
	logic [15:0] res;
	logic [15:0] yaw;
	cmd_t cmd;
	stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{16{offset_q[15]}}, offset_q} : 32'd0;
	assign rx_byte_ready = !busy && !out_valid && !start;
	assign acc = rx_byte_valid && rx_byte_ready;
	assign yaw = {rx_byte, yaw_lo_q};
	assign wr_en = acc && byte_count_q == 4'd7 && type_q == AngleType;

	// Config register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			offset_q <= pwdata[15:0];
		end
	end

	// Frame parser and window pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			pos_q <= '0;
			full_q <= 1'b0;
			start <= 1'b0;
			type_q <= '0;
			yaw_lo_q <= '0;
		end else begin
			start <= 1'b0;
			if (acc) begin
				if (byte_count_q == 4'd0 && rx_byte != SyncByte) begin
					byte_count_q <= '0;
				end else begin
					byte_count_q <= (byte_count_q == FrameLen - 1) ? 4'd0 : byte_count_q + 1'b1;
				end
				if (byte_count_q == 4'd1) type_q <= rx_byte;
				if (byte_count_q == 4'd6) yaw_lo_q <= rx_byte;
				if (wr_en) begin
					pos_q <= (pos_q == WinIdxW'(Window - 1)) ? '0 : pos_q + 1'b1;
					if (pos_q == WinIdxW'(Window - 1)) full_q <= 1'b1;
				end
				if (byte_count_q == FrameLen - 1 && type_q == AngleType && full_q) start <= 1'b1;
			end
		end
	end

	ifhf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.busy(busy), .done(done), .cmd(cmd)
	);

	ifhf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_yaw(yaw), .wr_idx(pos_q),
		.cmd(cmd), .stat(stat), .result(res)
	);

	// Output register with degree conversion.
	logic [15:0] h;
	logic [24:0] prod;
	assign h = res + offset_q;
	assign prod = 25'(h) * 25'd360;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			heading <= '0;
			heading_deg <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (done) begin
				out_valid <= 1'b1;
				heading <= h;
				heading_deg <= prod[24:16];
			end
		end
	end
endmodule

// ===== tb/sv/heading_checker.sv =====
// Checker for the IMU frame heading filter: follows the byte, result and config channels,
// predicts every heading and compares it. Depends on ifhf_pkg for the sizes and codes.
`timescale 1ns / 1ps
module heading_checker import ifhf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_byte_valid,
	input  logic        rx_byte_ready,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] heading,
	input  logic [8:0]  heading_deg,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	localparam logic [2:0] OffsetAddr = 3'd0;

	typedef struct {
		logic [15:0] heading;
		logic [8:0]  deg;
	} heading_t;

	heading_t     heading_q[$];
	logic [3:0]   frm_cnt;
	logic [7:0]   frm[FrameLen];
	logic [15:0]  yaw_ring[Window];
	int           ring_pos;
	bit           ring_full;
	logic [15:0]  offset_reg;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic longint arctan_step(input int i);
		longint tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};
		return tab[i];
	endfunction

	function automatic longint sext16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	// Rotation CORDIC giving a Q1.15 unit vector for a binary angle.
	function automatic void rotate_unit(input logic [15:0] ang, output longint c,
			output longint s);
		bit flip;
		longint x, y, z, nx;
		logic [15:0] q;
		flip = 0;
		x = 5093946;
		y = 0;
		q = ang + 16'd16384;
		if (q[15]) begin
			ang = ang ^ 16'h8000;
			flip = 1;
		end
		z = sext16(ang) * 65536;
		for (int i = 0; i < CordicSteps && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_step(i);
			end
			x = nx;
		end
		x = (x + 128) >>> 8;
		y = (y + 128) >>> 8;
		if (x > 32767) x = 32767;
		if (x < -32767) x = -32767;
		if (y > 32767) y = 32767;
		if (y < -32767) y = -32767;
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = x;
		s = y;
	endfunction

	// Vectoring CORDIC: angle of the summed vector, rounded to 16 bits.
	function automatic logic [15:0] vector_angle(input longint y, input longint x);
		logic [15:0] base;
		longint z, nx;
		base = 16'd0;
		z = 0;
		if (x == 0 && y == 0) return 16'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			base = 16'h8000;
		end
		x = x * 65536;
		y = y * 65536;
		for (int i = 0; i < CordicSteps && i < 24; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_step(i);
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_step(i);
			end
			x = nx;
		end
		z = (z + 32768) >>> 16;
		return base + z[15:0];
	endfunction

	// Trimmed circular mean over the yaw ring.
	function automatic logic [15:0] trimmed_mean();
		longint cs[Window], sn[Window];
		longint sc, ss, d, dmin, dmax;
		logic [15:0] mean;
		int imin, imax;
		sc = 0;
		ss = 0;
		dmin = 0;
		dmax = 0;
		imin = 0;
		imax = Window;
		for (int j = 0; j < Window; j++) begin
			rotate_unit(yaw_ring[j], cs[j], sn[j]);
			sc += cs[j];
			ss += sn[j];
		end
		mean = vector_angle(ss, sc);
		for (int j = 0; j < Window; j++) begin
			d = sext16(yaw_ring[j] - mean);
			if (j == 0 || d < dmin) begin
				dmin = d;
				imin = j;
			end
		end
		for (int j = 0; j < Window; j++) begin
			d = sext16(yaw_ring[j] - mean);
			if (j != imin && (imax == Window || d > dmax)) begin
				dmax = d;
				imax = j;
			end
		end
		sc -= cs[imin];
		ss -= sn[imin];
		if (imax < Window) begin
			sc -= cs[imax];
			ss -= sn[imax];
		end
		return vector_angle(ss, sc);
	endfunction

	// Framing and window update for one accepted byte.
	task automatic take_byte(input logic [7:0] b);
		heading_t e;
		logic [31:0] prod;
		if (frm_cnt >= FrameLen) frm_cnt = 0;
		frm[frm_cnt] = b;
		if (frm[0] != SyncByte) begin
			frm_cnt = 0;
			return;
		end
		frm_cnt++;
		if (frm_cnt < FrameLen) return;
		frm_cnt = 0;
		if (frm[1] != AngleType) return;
		yaw_ring[ring_pos] = {frm[7], frm[6]};
		ring_pos++;
		if (ring_pos >= Window) begin
			ring_full = 1;
			ring_pos = 0;
		end
		if (!ring_full) return;
		e.heading = trimmed_mean() + offset_reg;
		prod = {16'd0, e.heading} * 32'd360;
		e.deg = prod[24:16];
		heading_q.push_back(e);
	endtask

	assign pending = heading_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_cnt = 0;
			ring_pos = 0;
			ring_full = 0;
			offset_reg = 16'd0;
			fail_count = 0;
			heading_q.delete();
		end else begin
			// Config writes land at the access cycle.
			if (psel && penable && pwrite && pready && paddr == OffsetAddr)
				offset_reg = pwdata[15:0];
			if (rx_byte_valid && rx_byte_ready)
				take_byte(rx_byte);
			// Compare each result word with the oldest prediction.
			if (out_valid && out_ready) begin
				if (heading_q.size() == 0) begin
					$error("unexpected heading word %0d", heading);
					fail_count++;
				end else begin
					heading_t e;
					e = heading_q.pop_front();
					if (heading !== e.heading) begin
						$error("heading: expected %0d actual %0d", e.heading, heading);
						fail_count++;
					end
					if (heading_deg !== e.deg) begin
						$error("heading_deg: expected %0d actual %0d", e.deg, heading_deg);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Top of the heading filter testbench: clock, reset, byte stimulus, config writes, verdict.
// Depends on ifhf_pkg, imu_frame_heading_filter_core and heading_checker.
`timescale 1ns / 1ps
module testbench;
	import ifhf_pkg::*;

	localparam int StallLimit = 5000;
	localparam int DrainCycles = 400;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        rx_byte_valid = 0;
	logic        rx_byte_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [15:0] heading;
	logic [8:0]  heading_deg;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          ready_mode = 0;
	logic [7:0]  byte_q[$];

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	imu_frame_heading_filter_core u_dut (.*);

	heading_checker u_chk (.*);

	// Receiver stalls: the mode changes every so often.
	always @(posedge clk) begin
		if ($urandom_range(63) == 0) ready_mode <= $urandom_range(2);
		case (ready_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(1));
			end
			default: begin
				out_ready <= ($urandom_range(7) == 0);
			end
		endcase
	end

	// Watchdog on cycles with work waiting but no word moving.
	always @(posedge clk) begin
		if ((rx_byte_valid && rx_byte_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (rx_byte_valid || pending > 0)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_frame(input logic [7:0] ftype, input logic [15:0] yaw);
		byte_q.push_back(SyncByte);
		byte_q.push_back(ftype);
		for (int i = 2; i < FrameLen; i++) begin
			if (i == 6) byte_q.push_back(yaw[7:0]);
			else if (i == 7) byte_q.push_back(yaw[15:8]);
			else byte_q.push_back(8'($urandom_range(255)));
		end
	endtask

	// Sends the queued bytes in bursts with random gaps.
	task automatic send_all();
		int gap;
		while (byte_q.size() > 0) begin
			rx_byte_valid <= 1'b1;
			rx_byte <= byte_q.pop_front();
			do @(posedge clk); while (!rx_byte_ready);
			if (burst_left == 0) begin
				burst_left = $urandom_range(40);
				gap = $urandom_range(12);
				if (gap > 0) begin
					rx_byte_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
		rx_byte_valid <= 1'b0;
	endtask

	// Waits until every heading is out and the filter has settled.
	task automatic drain();
		while (pending > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_offset(input logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd0;
		pwdata <= {{16{v[15]}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Random part: mostly angle frames around a drifting center, some noise.
	task automatic random_phase(input int n_bytes);
		logic [15:0] center, yaw;
		int r;
		center = 16'($urandom_range(65535));
		while (byte_q.size() < n_bytes) begin
			r = $urandom_range(99);
			if (r < 5) begin
				byte_q.push_back(8'($urandom_range(255)));
			end else if (r < 10) begin
				push_frame(8'($urandom_range(255)), 16'($urandom_range(65535)));
			end else if (r < 13) begin
				byte_q.push_back(SyncByte);
				byte_q.push_back(AngleType);
			end else begin
				if ($urandom_range(3) == 0) yaw = 16'($urandom_range(65535));
				else yaw = center + 16'($urandom_range(4000)) - 16'd2000;
				if ($urandom_range(15) == 0) center = 16'($urandom_range(65535));
				push_frame(AngleType, yaw);
			end
		end
		send_all();
	endtask

	initial begin
		logic [15:0] extremes[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lost sync, foreign frame type, filling, half circle, zero vector, quarter circle.
		byte_q.push_back(8'h00);
		byte_q.push_back(8'hFF);
		push_frame(8'h51, 16'h1234);
		for (int i = 0; i < 8; i++) push_frame(AngleType, extremes[i % 4]);
		for (int i = 0; i < 8; i++) push_frame(AngleType, 16'h8000);
		for (int i = 0; i < 8; i++) push_frame(AngleType, (i % 2) ? 16'h8000 : 16'h0000);
		for (int i = 0; i < 8; i++) push_frame(AngleType, 16'h4000);
		send_all();
		drain();

		write_offset(16'h7FFF);
		random_phase(290);
		drain();
		write_offset(16'h8000);
		random_phase(290);
		drain();
		write_offset(16'($urandom_range(65535)));
		random_phase(290);
		drain();
		write_offset(16'h0000);
		random_phase(290);
		drain();

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/ifhf_pkg.sv
hw/rtl/ifhf_ctrl.sv
hw/rtl/ifhf_dp.sv
hw/rtl/imu_frame_heading_filter_core.sv
tb/sv/heading_checker.sv
tb/sv/testbench.sv
